/* design/tvr_pkg.sv */
// Shared constants and types for the trilinear volume resampler.
package tvr_pkg;

  localparam int MAX_SOURCE_DIM = 64;
  localparam int MAX_TARGET_DIM = 1024;
  localparam int VOXEL_BITS     = 16;

  localparam int SRC_IDX_BITS = $clog2(MAX_SOURCE_DIM);
  localparam int TGT_M1_BITS  = $clog2(MAX_TARGET_DIM);
  localparam int SRC_REG_BITS = 7;
  localparam int TGT_REG_BITS = 11;
  localparam int COORD_BITS   = 10;
  localparam int W_BITS       = 16;
  localparam int FACTOR_BITS  = SRC_IDX_BITS + W_BITS;
  localparam int ADDR_BITS    = 3 * SRC_IDX_BITS;
  localparam int VOL_DEPTH    = MAX_SOURCE_DIM * MAX_SOURCE_DIM * MAX_SOURCE_DIM;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = TGT_REG_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_Z = 3'd5;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [VOXEL_BITS-1:0] voxel_t;
  typedef logic [FACTOR_BITS-1:0]       factor_t;
  typedef logic [TGT_M1_BITS-1:0]       tgt_m1_t;
  typedef logic [SRC_IDX_BITS-1:0]      src_idx_t;

endpackage

/* design/tvr_div.sv */
// Restoring divider, one quotient bit per cycle, for the per-axis scale factors.
module tvr_div import tvr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  factor_t dividend,
  input  tgt_m1_t divisor,
  output logic    done,
  output factor_t quotient
);

  localparam int CNT_BITS = $clog2(FACTOR_BITS);

  logic                  busy;
  logic [CNT_BITS-1:0]   cnt;
  tgt_m1_t               rem;
  tgt_m1_t               dvs;
  factor_t               dq;
  logic [TGT_M1_BITS:0]  rem_sh;
  logic [TGT_M1_BITS:0]  rem_diff;
  logic                  ge;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    rem_sh   = {rem, dq[FACTOR_BITS-1]};
    rem_diff = rem_sh - {1'b0, dvs};
    ge       = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_BITS'(1);
        if (cnt == CNT_BITS'(FACTOR_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend bits leave at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[FACTOR_BITS-2:0], ge};
      rem <= ge ? rem_diff[TGT_M1_BITS-1:0] : rem_sh[TGT_M1_BITS-1:0];
    end
  end

  assign quotient = dq;

endmodule

/* design/trilinear_volume_resampler_unit.sv */
// Trilinear volume resampler: voxel store, factor divider sequencer and shared multiplier.
// Load beat: one cycle, written at the accepting edge; one load per cycle when not stalled.
// Query beat: positions, corner reads, lerps, then the push; no new beat until the push. The
//   single shared multiplier (3 positions, 7 lerps) and the single-port voxel memory set this.
// Reset clears control state and sets all sizes to 64; after reset and after any register
//   write, in_stall stays high while the restoring divider rebuilds the three scale factors
//   (an axis with target size one takes a zero factor). The voxel memory is not cleared.
module trilinear_volume_resampler_unit import tvr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     operation,
  input  logic [COORD_BITS-1:0]    coord_x,
  input  logic [COORD_BITS-1:0]    coord_y,
  input  logic [COORD_BITS-1:0]    coord_z,
  input  voxel_t                   voxel_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output voxel_t                   interpolated_value
);

  localparam int MUL_A_BITS = FACTOR_BITS + 1;
  localparam int MUL_B_BITS = W_BITS + 2;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DIV_GO   = 4'd1;
  localparam logic [3:0] ST_DIV_WAIT = 4'd2;
  localparam logic [3:0] ST_POS_MUL  = 4'd3;
  localparam logic [3:0] ST_POS_PICK = 4'd4;
  localparam logic [3:0] ST_RD_A     = 4'd5;
  localparam logic [3:0] ST_RD_B     = 4'd6;
  localparam logic [3:0] ST_RD_W     = 4'd7;
  localparam logic [3:0] ST_SEL      = 4'd8;
  localparam logic [3:0] ST_LERP_MUL = 4'd9;
  localparam logic [3:0] ST_LERP_FIN = 4'd10;
  localparam logic [3:0] ST_PUSH     = 4'd11;

  // Lerp steps: four along x, two along y, one along z.
  localparam logic [2:0] LI_A00 = 3'd0;
  localparam logic [2:0] LI_A01 = 3'd1;
  localparam logic [2:0] LI_A10 = 3'd2;
  localparam logic [2:0] LI_A11 = 3'd3;
  localparam logic [2:0] LI_B0  = 3'd4;
  localparam logic [2:0] LI_B1  = 3'd5;
  localparam logic [2:0] LI_R   = 3'd6;

  localparam logic [1:0] AX_LAST = 2'd2;

  // Configuration registers, raw as written.
  logic [SRC_REG_BITS-1:0] src_size [0:2];
  logic [TGT_REG_BITS-1:0] tgt_size [0:2];
  src_idx_t                src_m1   [0:2];
  tgt_m1_t                 tgt_m1   [0:2];

  // Sequencer.
  logic [3:0] state;
  logic       dirty;
  logic [1:0] ax;
  logic [2:0] li;

  // Per-axis query data.
  factor_t               factor [0:2];
  logic [COORD_BITS-1:0] crd    [0:2];
  src_idx_t              lo_idx [0:2];
  src_idx_t              hi_idx [0:2];
  logic [W_BITS-1:0]     wgt    [0:2];

  // Lerp operands and partial results.
  voxel_t            op_a;
  voxel_t            op_b;
  logic [W_BITS-1:0] op_w;
  voxel_t            a00, a01, a10, a11, b0, b1, result;

  // Shared multiplier.
  logic signed [MUL_A_BITS-1:0] mul_a;
  logic signed [MUL_B_BITS-1:0] mul_b;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [VOXEL_BITS:0]   diff;

  // Volume memory.
  voxel_t                vol_mem [0:VOL_DEPTH-1];
  voxel_t                mem_rdata;
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_addr;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [ADDR_BITS-1:0]  ld_addr;

  logic in_accept;
  logic ld_in_range;
  logic out_free;

  // Divider hookup.
  logic    div_start;
  logic    div_done;
  factor_t div_quot;

  // Position pick.
  logic [PROD_BITS-W_BITS-1:0] ip;
  logic                        over;
  src_idx_t                    pick_lo;
  src_idx_t                    pick_hi;
  logic [W_BITS-1:0]           pick_w;

  // Lerp finish: add a scaled by one, then truncate toward zero.
  logic signed [PROD_BITS-1:0] lerp_sum;
  logic signed [PROD_BITS-1:0] lerp_rnd;
  voxel_t                      lerp_res;

  // Clamp the size registers: zero acts as one, above the maximum acts as the maximum.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (src_size[k] == '0) begin
        src_m1[k] = '0;
      end else if (src_size[k] > SRC_REG_BITS'(MAX_SOURCE_DIM)) begin
        src_m1[k] = SRC_IDX_BITS'(MAX_SOURCE_DIM - 1);
      end else begin
        src_m1[k] = SRC_IDX_BITS'(src_size[k] - SRC_REG_BITS'(1));
      end
      if (tgt_size[k] == '0) begin
        tgt_m1[k] = '0;
      end else if (tgt_size[k] > TGT_REG_BITS'(MAX_TARGET_DIM)) begin
        tgt_m1[k] = TGT_M1_BITS'(MAX_TARGET_DIM - 1);
      end else begin
        tgt_m1[k] = TGT_M1_BITS'(tgt_size[k] - TGT_REG_BITS'(1));
      end
    end
  end

  // Hold off input beats while busy or while the factors are stale.
  assign in_stall  = (state != ST_IDLE) || dirty;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign ld_in_range = (coord_x <= COORD_BITS'(src_m1[0])) &&
                       (coord_y <= COORD_BITS'(src_m1[1])) &&
                       (coord_z <= COORD_BITS'(src_m1[2]));
  // Drop loads outside the source volume.
  assign mem_we  = in_accept && (operation == OP_LOAD) && ld_in_range;
  assign ld_addr = {coord_x[SRC_IDX_BITS-1:0], coord_y[SRC_IDX_BITS-1:0],
                    coord_z[SRC_IDX_BITS-1:0]};

  // Corner address: x picks by the read phase, y and z by the x-lerp step.
  assign rd_addr = {(state == ST_RD_B) ? hi_idx[0] : lo_idx[0],
                    li[0] ? hi_idx[1] : lo_idx[1],
                    li[1] ? hi_idx[2] : lo_idx[2]};
  assign mem_addr = mem_we ? ld_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vol_mem[mem_addr] <= voxel_value;
    end else begin
      mem_rdata <= vol_mem[mem_addr];
    end
  end

  // One multiplier serves both position = factor * coord and the lerp term w * (b - a).
  always_comb begin
    diff = {op_b[VOXEL_BITS-1], op_b} - {op_a[VOXEL_BITS-1], op_a};
    if (state == ST_POS_MUL) begin
      mul_a = {1'b0, factor[ax]};
      mul_b = {{(MUL_B_BITS-COORD_BITS){1'b0}}, crd[ax]};
    end else begin
      mul_a = {{(MUL_A_BITS-VOXEL_BITS-1){diff[VOXEL_BITS]}}, diff};
      mul_b = {2'b00, op_w};
    end
  end

  always_comb begin
    ip      = prod[PROD_BITS-1:W_BITS];
    over    = ip > (PROD_BITS-W_BITS)'(src_m1[ax]);
    pick_lo = over ? src_m1[ax] : ip[SRC_IDX_BITS-1:0];
    pick_w  = over ? '0 : prod[W_BITS-1:0];
    // Hold the upper neighbor at the last index.
    pick_hi = (pick_lo == src_m1[ax]) ? pick_lo : pick_lo + SRC_IDX_BITS'(1);
  end

  always_comb begin
    lerp_sum = {{(PROD_BITS-VOXEL_BITS-W_BITS){op_a[VOXEL_BITS-1]}}, op_a, {W_BITS{1'b0}}}
               + prod;
    lerp_rnd = lerp_sum[PROD_BITS-1] ? lerp_sum + PROD_BITS'((1 << W_BITS) - 1) : lerp_sum;
    lerp_res = lerp_rnd[VOXEL_BITS+W_BITS-1:W_BITS];
  end

  assign div_start = (state == ST_DIV_GO) && (tgt_m1[ax] != '0);

  tvr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({src_m1[ax], {W_BITS{1'b0}}}),
    .divisor  (tgt_m1[ax]),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Control: sequencer, stale-factor flag, output valid, configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dirty     <= 1'b1;
      ax        <= '0;
      li        <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        src_size[k] <= SRC_REG_BITS'(64);
        tgt_size[k] <= TGT_REG_BITS'(64);
      end
    end else begin
      if (cfg_we) begin
        dirty <= 1'b1;
        unique case (cfg_index)
          CFG_SOURCE_X: src_size[0] <= cfg_data[SRC_REG_BITS-1:0];
          CFG_SOURCE_Y: src_size[1] <= cfg_data[SRC_REG_BITS-1:0];
          CFG_SOURCE_Z: src_size[2] <= cfg_data[SRC_REG_BITS-1:0];
          CFG_TARGET_X: tgt_size[0] <= cfg_data;
          CFG_TARGET_Y: tgt_size[1] <= cfg_data;
          CFG_TARGET_Z: tgt_size[2] <= cfg_data;
          default: ;
        endcase
      end else if (state == ST_IDLE && dirty) begin
        dirty <= 1'b0;
      end

      if (state == ST_PUSH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (dirty) begin
            ax    <= '0;
            state <= ST_DIV_GO;
          end else if (in_valid && operation == OP_QUERY) begin
            ax    <= '0;
            state <= ST_POS_MUL;
          end
        end
        ST_DIV_GO: begin
          if (tgt_m1[ax] != '0) begin
            state <= ST_DIV_WAIT;
          end else if (ax == AX_LAST) begin
            state <= ST_IDLE;
          end else begin
            ax <= ax + 2'd1;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (ax == AX_LAST) begin
              state <= ST_IDLE;
            end else begin
              ax    <= ax + 2'd1;
              state <= ST_DIV_GO;
            end
          end
        end
        ST_POS_MUL: state <= ST_POS_PICK;
        ST_POS_PICK: begin
          if (ax == AX_LAST) begin
            li    <= LI_A00;
            state <= ST_RD_A;
          end else begin
            ax    <= ax + 2'd1;
            state <= ST_POS_MUL;
          end
        end
        ST_RD_A:     state <= ST_RD_B;
        ST_RD_B:     state <= ST_RD_W;
        ST_RD_W:     state <= ST_LERP_MUL;
        ST_SEL:      state <= ST_LERP_MUL;
        ST_LERP_MUL: state <= ST_LERP_FIN;
        ST_LERP_FIN: begin
          if (li == LI_R) begin
            state <= ST_PUSH;
          end else begin
            li    <= li + 3'd1;
            state <= (li == LI_A11 || li == LI_B0 || li == LI_B1) ? ST_SEL : ST_RD_A;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept) begin
      crd[0] <= coord_x;
      crd[1] <= coord_y;
      crd[2] <= coord_z;
    end
    if (state == ST_DIV_GO && tgt_m1[ax] == '0) begin
      factor[ax] <= '0;
    end
    if (state == ST_DIV_WAIT && div_done) begin
      factor[ax] <= div_quot;
    end
    if (state == ST_POS_MUL || state == ST_LERP_MUL) begin
      prod <= mul_a * mul_b;
    end
    if (state == ST_POS_PICK) begin
      lo_idx[ax] <= pick_lo;
      hi_idx[ax] <= pick_hi;
      wgt[ax]    <= pick_w;
    end
    // Read data is registered, so each corner value arrives in the state after its address.
    if (state == ST_RD_B) begin
      op_a <= mem_rdata;
    end
    if (state == ST_RD_W) begin
      op_b <= mem_rdata;
      op_w <= wgt[0];
    end
    if (state == ST_SEL) begin
      priority case (li)
        LI_B0: begin
          op_a <= a00;
          op_b <= a01;
          op_w <= wgt[1];
        end
        LI_B1: begin
          op_a <= a10;
          op_b <= a11;
          op_w <= wgt[1];
        end
        default: begin
          op_a <= b0;
          op_b <= b1;
          op_w <= wgt[2];
        end
      endcase
    end
    if (state == ST_LERP_FIN) begin
      unique case (li)
        LI_A00:  a00    <= lerp_res;
        LI_A01:  a01    <= lerp_res;
        LI_A10:  a10    <= lerp_res;
        LI_A11:  a11    <= lerp_res;
        LI_B0:   b0     <= lerp_res;
        LI_B1:   b1     <= lerp_res;
        default: result <= lerp_res;
      endcase
    end
    if (state == ST_PUSH && out_free) begin
      interpolated_value <= result;
    end
  end

endmodule

/* tb/sv/trilinear_volume_resampler_unit_tb.sv */
// Self-checking testbench for the trilinear volume resampler: voxel loads, queries, size registers.
module trilinear_volume_resampler_unit_tb;
  import tvr_pkg::*;

  localparam int     LIMIT_CYCLES  = 1_000_000;
  localparam int     SETTLE_CYCLES = 48;
  localparam int     ITEM_GOAL     = 1600;
  localparam longint ONE_Q16       = 65536;

  // One axis of a query: both neighbours and the Q0.16 weight between them.
  typedef struct {
    int     lo;
    int     hi;
    longint frac;
  } span_t;

  logic                     clk         = 1'b0;
  logic                     rst         = 1'b1;
  logic                     cfg_we      = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data    = '0;
  logic                     in_valid    = 1'b0;
  logic                     in_stall;
  logic                     operation   = OP_LOAD;
  logic [COORD_BITS-1:0]    coord_x     = '0;
  logic [COORD_BITS-1:0]    coord_y     = '0;
  logic [COORD_BITS-1:0]    coord_z     = '0;
  voxel_t                   voxel_value = '0;
  logic                     out_valid;
  logic                     out_stall   = 1'b0;
  voxel_t                   interpolated_value;

  always #5 clk = ~clk;

  trilinear_volume_resampler_unit u_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .operation          (operation),
    .coord_x            (coord_x),
    .coord_y            (coord_y),
    .coord_z            (coord_z),
    .voxel_value        (voxel_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .interpolated_value (interpolated_value)
  );

  // Mirror of the voxel memory plus a map of which entries hold a known value.
  // The memory is not cleared by reset, so a query may only touch entries marked here.
  voxel_t                   vol_mirror  [VOL_DEPTH];
  bit                       vol_written [VOL_DEPTH];
  logic [CFG_DATA_BITS-1:0] size_regs   [6];
  voxel_t                   expected_voxels [$];
  voxel_t                   want_voxel;

  int mismatch_count = 0;
  int useful_beats   = 0;   // stored loads and queries; dropped loads do not count
  int burst_left     = 0;
  int hold_request   = 0;
  bit sender_gaps    = 1'b1;

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // Slots 0..2 are the source sizes, 3..5 the target sizes.
  function automatic logic [CFG_IDX_BITS-1:0] size_reg_index(int slot);
    case (slot)
      0:       return CFG_SOURCE_X;
      1:       return CFG_SOURCE_Y;
      2:       return CFG_SOURCE_Z;
      3:       return CFG_TARGET_X;
      4:       return CFG_TARGET_Y;
      default: return CFG_TARGET_Z;
    endcase
  endfunction

  // Zero acts as one, anything past the maximum acts as the maximum.
  function automatic int src_extent(int axis);
    int v;
    v = int'(size_regs[size_reg_index(axis)]);
    if (v < 1) return 1;
    if (v > MAX_SOURCE_DIM) return MAX_SOURCE_DIM;
    return v;
  endfunction

  function automatic int tgt_extent(int axis);
    int v;
    v = int'(size_regs[size_reg_index(axis + 3)]);
    if (v < 1) return 1;
    if (v > MAX_TARGET_DIM) return MAX_TARGET_DIM;
    return v;
  endfunction

  function automatic int vox_addr(int x, int y, int z);
    return (x * MAX_SOURCE_DIM + y) * MAX_SOURCE_DIM + z;
  endfunction

  // Scale factor (src-1)/(tgt-1) in truncated Q6.16; a position whose integer part runs
  // past the last source index pins to that index with no fraction.
  function automatic span_t axis_span(int axis, int coord);
    longint src;
    longint tgt;
    longint factor;
    longint pos;
    longint ip;
    span_t  s;
    src    = src_extent(axis);
    tgt    = tgt_extent(axis);
    factor = 0;
    if (tgt > 1) factor = ((src - 1) <<< 16) / (tgt - 1);
    pos = factor * coord;
    ip  = pos >>> 16;
    if (ip > src - 1) begin
      s.lo   = int'(src - 1);
      s.frac = 0;
    end else begin
      s.lo   = int'(ip);
      s.frac = pos & 64'hFFFF;
    end
    s.hi = (s.lo + 1 < src) ? s.lo + 1 : int'(src - 1);
    return s;
  endfunction

  // Exact weighted sum, truncated toward zero.
  function automatic longint blend_q16(longint a, longint b, longint w);
    return ((ONE_Q16 - w) * a + w * b) / ONE_Q16;
  endfunction

  function automatic longint voxel_at(int x, int y, int z);
    return longint'(vol_mirror[vox_addr(x, y, z)]);
  endfunction

  // Four lerps along x, two along y, one along z.
  function automatic voxel_t trilerp_value(int cx, int cy, int cz);
    span_t  sx;
    span_t  sy;
    span_t  sz;
    longint a00;
    longint a01;
    longint a10;
    longint a11;
    longint b0;
    longint b1;
    longint r;
    sx  = axis_span(0, cx);
    sy  = axis_span(1, cy);
    sz  = axis_span(2, cz);
    a00 = blend_q16(voxel_at(sx.lo, sy.lo, sz.lo), voxel_at(sx.hi, sy.lo, sz.lo), sx.frac);
    a01 = blend_q16(voxel_at(sx.lo, sy.hi, sz.lo), voxel_at(sx.hi, sy.hi, sz.lo), sx.frac);
    a10 = blend_q16(voxel_at(sx.lo, sy.lo, sz.hi), voxel_at(sx.hi, sy.lo, sz.hi), sx.frac);
    a11 = blend_q16(voxel_at(sx.lo, sy.hi, sz.hi), voxel_at(sx.hi, sy.hi, sz.hi), sx.frac);
    b0  = blend_q16(a00, a01, sy.frac);
    b1  = blend_q16(a10, a11, sy.frac);
    r   = blend_q16(b0, b1, sz.frac);
    return voxel_t'(r);
  endfunction

  // Apply one accepted beat: a load inside the source size lands in the mirror, a load
  // outside it is dropped, a query queues its expected voxel.
  function automatic void absorb_beat(logic op, int cx, int cy, int cz, voxel_t v);
    int a;
    if (op == OP_LOAD) begin
      if (cx < src_extent(0) && cy < src_extent(1) && cz < src_extent(2)) begin
        a              = vox_addr(cx, cy, cz);
        vol_mirror[a]  = v;
        vol_written[a] = 1'b1;
        useful_beats++;
      end
    end else begin
      expected_voxels.push_back(trilerp_value(cx, cy, cz));
      useful_beats++;
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------------------

  function automatic voxel_t random_voxel();
    case ($urandom_range(0, 11))
      0:       return voxel_t'(-32768);
      1:       return voxel_t'(32767);
      2:       return voxel_t'(-1);
      3:       return voxel_t'(0);
      default: return voxel_t'($urandom);
    endcase
  endfunction

  // Offer one beat and hold it until accepted; then maybe close the burst with a gap.
  // Valid stays high into the next beat when no gap follows.
  task automatic put_beat(logic op, int cx, int cy, int cz, voxel_t v);
    int gap;
    in_valid    <= 1'b1;
    operation   <= op;
    coord_x     <= COORD_BITS'(cx);
    coord_y     <= COORD_BITS'(cy);
    coord_z     <= COORD_BITS'(cz);
    voxel_value <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    absorb_beat(op, cx, cy, cz, v);
    if (sender_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 24);
        gap        = $urandom_range(1, 9);
        in_valid  <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Load any of the eight neighbours that hold no known value yet, then send the query.
  task automatic put_query(int cx, int cy, int cz);
    span_t sx;
    span_t sy;
    span_t sz;
    int    x;
    int    y;
    int    z;
    sx = axis_span(0, cx);
    sy = axis_span(1, cy);
    sz = axis_span(2, cz);
    for (int i = 0; i < 8; i++) begin
      x = i[0] ? sx.hi : sx.lo;
      y = i[1] ? sy.hi : sy.lo;
      z = i[2] ? sz.hi : sz.lo;
      if (!vol_written[vox_addr(x, y, z)]) put_beat(OP_LOAD, x, y, z, random_voxel());
    end
    put_beat(OP_QUERY, cx, cy, cz, random_voxel());
  endtask

  // Drop valid, let every outstanding result drain, then give the datapath time to settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_voxels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Wait for the block to go idle, then write all six size registers on back-to-back cycles.
  task automatic set_sizes(int sx, int sy, int sz, int tx, int ty, int tz);
    int vals [6];
    vals = '{sx, sy, sz, tx, ty, tz};
    wait_idle();
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= size_reg_index(i);
      cfg_data  <= CFG_DATA_BITS'(vals[i]);
      @(posedge clk);
      if (i < 3)
        size_regs[size_reg_index(i)] = CFG_DATA_BITS'(vals[i] & ((1 << SRC_REG_BITS) - 1));
      else
        size_regs[size_reg_index(i)] = CFG_DATA_BITS'(vals[i] & ((1 << TGT_REG_BITS) - 1));
    end
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------------------

  // Stall on a pattern of shifting density; a requested hold-off overrides it and is
  // counted down here, cycle by cycle.
  int hold_left    = 0;
  int pattern_left = 0;
  int stall_pct    = 0;

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 320);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      pattern_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare every accepted result beat with the oldest expected voxel.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_voxels.size() == 0) begin
        $display("%0t: interpolated_value: expected none, actual %0d", $time,
                 interpolated_value);
        mismatch_count++;
      end else begin
        want_voxel = expected_voxels.pop_front();
        if (interpolated_value !== want_voxel) begin
          $display("%0t: interpolated_value: expected %0d, actual %0d", $time, want_voxel,
                   interpolated_value);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Out of reset every size is 64: a factor of exactly one, so no fraction anywhere.
  // Include the corners, the voxel extremes and a query far past the target size.
  task automatic test_reset_sizes();
    put_beat(OP_LOAD, 0, 0, 0, voxel_t'(-32768));
    put_beat(OP_LOAD, 63, 63, 63, voxel_t'(32767));
    put_query(0, 0, 0);
    put_query(63, 63, 63);
    put_query(1023, 1023, 1023);
    put_query(40, 7, 22);
  endtask

  // Two source voxels onto three outputs: coordinate 1 falls halfway on each axis, with signs mixed
  // so that negative halves must truncate toward zero.
  task automatic test_half_steps();
    set_sizes(2, 2, 2, 3, 3, 3);
    put_beat(OP_LOAD, 0, 0, 0, voxel_t'(-32768));
    put_beat(OP_LOAD, 1, 0, 0, voxel_t'(32767));
    put_beat(OP_LOAD, 0, 1, 0, voxel_t'(-1));
    put_beat(OP_LOAD, 1, 1, 0, voxel_t'(0));
    put_beat(OP_LOAD, 0, 0, 1, voxel_t'(32767));
    put_beat(OP_LOAD, 1, 0, 1, voxel_t'(-32768));
    put_beat(OP_LOAD, 0, 1, 1, voxel_t'(-3));
    put_beat(OP_LOAD, 1, 1, 1, voxel_t'(0));
    put_query(1, 1, 1);
    put_query(1, 0, 2);
    put_query(2, 2, 2);
    put_query(0, 1, 0);
  endtask

  // Register codes out of range: zero source and target (act as one), source code above
  // 64, target code above 1024, and source bits above the register width (dropped).
  // The y axis then runs at the largest target size with a fine fractional factor.
  task automatic test_degenerate_axes();
    set_sizes(0, 127, 'h782, 1, 2047, 0);
    put_query(5, 1023, 1023);
    put_query(0, 512, 0);
    put_query(1023, 0, 1);
    put_query(0, 1, 0);
  endtask

  // Loads past the source size must not touch memory, including one whose low address
  // bits alias an in-range entry; enlarging the size again exposes the old values.
  task automatic test_ignored_loads();
    set_sizes(3, 1, 1, 5, 1, 1);
    put_beat(OP_LOAD, 2, 0, 0, voxel_t'(1234));
    set_sizes(2, 1, 1, 5, 1, 1);
    put_beat(OP_LOAD, 2, 0, 0, voxel_t'(-777));
    put_beat(OP_LOAD, 1, 0, 0, voxel_t'(-20000));
    put_beat(OP_LOAD, 65, 0, 0, voxel_t'(31000));
    put_beat(OP_LOAD, 1, 1000, 0, voxel_t'(5));
    put_beat(OP_LOAD, 0, 0, 513, voxel_t'(5));
    put_beat(OP_LOAD, 0, 0, 0, voxel_t'(77));
    set_sizes(3, 1, 1, 5, 1, 1);
    put_query(4, 0, 0);
    put_query(2, 0, 0);
    put_query(3, 0, 0);
    put_query(1, 0, 0);
  endtask

  // Hold the output off for a long stretch while queries keep coming back to back, so
  // the block fills and pushes back on its input.
  task automatic test_output_hold();
    set_sizes(4, 4, 4, 7, 7, 7);
    sender_gaps  = 1'b0;
    hold_request = 800;
    for (int i = 0; i < 40; i++)
      put_query($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6));
    sender_gaps = 1'b1;
  endtask

  function automatic int pick_src_extent();
    case ($urandom_range(0, 9))
      0:       return MAX_SOURCE_DIM;
      1:       return 1;
      2:       return 2;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int pick_tgt_extent();
    case ($urandom_range(0, 7))
      0:       return 1;
      1:       return MAX_TARGET_DIM;
      2:       return 2;
      3:       return $urandom_range(1, MAX_TARGET_DIM);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  // Encode a size as a register code, sometimes out of range or with stray upper bits.
  function automatic int src_code(int extent);
    int code;
    code = extent;
    if (extent == 1 && $urandom_range(0, 1)) code = 0;
    if (extent == MAX_SOURCE_DIM && $urandom_range(0, 1)) code = $urandom_range(65, 127);
    if ($urandom_range(0, 5) == 0) code = code | ($urandom_range(1, 15) << SRC_REG_BITS);
    return code;
  endfunction

  function automatic int tgt_code(int extent);
    if (extent == 1 && $urandom_range(0, 1)) return 0;
    if (extent == MAX_TARGET_DIM && $urandom_range(0, 1)) return $urandom_range(1025, 2047);
    return extent;
  endfunction

  // Mostly inside the target grid, sometimes past it, sometimes anywhere in the field.
  function automatic int pick_coord(int extent);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1023);
      1:       return (extent <= 1023) ? $urandom_range(extent, 1023) : 1023;
      default: return $urandom_range(0, extent - 1);
    endcase
  endfunction

  // Phases of: new sizes, a full load of the volume when it is small, then queries with
  // a sprinkle of dropped loads and overwrites.
  task automatic test_random_volumes();
    int es [3];
    int et [3];
    int nq;
    int ax;
    int c [3];
    while (useful_beats < ITEM_GOAL) begin
      for (int i = 0; i < 3; i++) begin
        es[i] = pick_src_extent();
        et[i] = pick_tgt_extent();
      end
      set_sizes(src_code(es[0]), src_code(es[1]), src_code(es[2]),
                tgt_code(et[0]), tgt_code(et[1]), tgt_code(et[2]));
      sender_gaps = ($urandom_range(0, 3) != 0);
      if (es[0] * es[1] * es[2] <= 256) begin
        for (int x = 0; x < es[0]; x++)
          for (int y = 0; y < es[1]; y++)
            for (int z = 0; z < es[2]; z++)
              put_beat(OP_LOAD, x, y, z, random_voxel());
      end
      nq = $urandom_range(8, 40);
      for (int q = 0; q < nq; q++) begin
        case ($urandom_range(0, 9))
          0: begin
            // drop: at least one axis past the source size
            ax = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) c[i] = $urandom_range(0, 1023);
            c[ax] = $urandom_range(es[ax], 1023);
            put_beat(OP_LOAD, c[0], c[1], c[2], random_voxel());
          end
          1: begin
            put_beat(OP_LOAD, $urandom_range(0, es[0] - 1), $urandom_range(0, es[1] - 1),
                     $urandom_range(0, es[2] - 1), random_voxel());
          end
          default: ;
        endcase
        put_query(pick_coord(et[0]), pick_coord(et[1]), pick_coord(et[2]));
      end
    end
    sender_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence and end of run
  // ---------------------------------------------------------------------------------------

  initial begin
    foreach (size_regs[i]) size_regs[i] = CFG_DATA_BITS'(64);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_sizes();
    test_half_steps();
    test_degenerate_axes();
    test_ignored_loads();
    test_output_hold();
    test_random_volumes();
    wait_idle();
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog: a correct run ends well inside this many cycles.
  initial begin : watchdog
    int cyc;
    for (cyc = 0; cyc < LIMIT_CYCLES; cyc++) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
design/tvr_pkg.sv
design/tvr_div.sv
design/trilinear_volume_resampler_unit.sv
tb/sv/trilinear_volume_resampler_unit_tb.sv
